// File: hw/rtl/igts_pkg.sv
// Shared types and constants for the idle-gated task scheduler.
`timescale 1ns / 1ps
`default_nettype none

package igts_pkg;

    localparam int TIME_W      = 48;
    localparam int PERIOD_W    = 31;
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int OUT_IDX_W   = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_CPU_IDLE_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IDLE_CHECKS_NEEDED = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_INTERVAL     = 2'd2;

    localparam logic [CFG_W-1:0] CPU_IDLE_THRESHOLD_RST = 16'd150;
    localparam logic [CFG_W-1:0] IDLE_CHECKS_NEEDED_RST = 16'd30;
    localparam logic [CFG_W-1:0] CHECK_INTERVAL_RST     = 16'd1000;
    localparam logic [CFG_W-1:0] IDLE_COUNT_MAX         = 16'hFFFF;

    typedef enum logic {
        CMD_POLL = 1'b0,
        CMD_ADD  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [TIME_W-1:0]     wall;
        logic [TIME_W-1:0]     cpu;
        logic [PERIOD_W-1:0]   period;
        logic [TIME_W-1:0]     due;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_push_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] interval;
        logic [TIME_W-1:0]   due;
    } task_t;

endpackage

`default_nettype wire

// File: hw/rtl/igts_front.sv
// Front end: accept items, classify them and precompute the first due time of an add.
`timescale 1ns / 1ps
`default_nettype none

module igts_front
    import igts_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic                func,
    input  wire logic [TIME_W-1:0]   wall_now,
    input  wire logic [TIME_W-1:0]   cpu_now,
    input  wire logic [PERIOD_W-1:0] task_period,
    output cmd_push_t                q_push,
    input  wire logic                q_full
);

    logic front_valid_reg;
    logic front_valid_next;
    cmd_t front_cmd_reg;
    cmd_t front_cmd_next;
    logic accept;
    logic handoff;

    assign handoff = front_valid_reg && !q_full;
    assign full    = front_valid_reg && q_full;
    assign accept  = push && !full;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        front_cmd_next   = front_cmd_reg;
        if (handoff)
        begin
            front_valid_next = 1'b0;
        end
        if (accept)
        begin
            front_valid_next      = 1'b1;
            front_cmd_next.kind   = func ? CMD_ADD : CMD_POLL;
            front_cmd_next.wall   = wall_now;
            front_cmd_next.cpu    = cpu_now;
            front_cmd_next.period = task_period;
            front_cmd_next.due    = wall_now + {{(TIME_W-PERIOD_W){1'b0}}, task_period};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_cmd_reg <= front_cmd_next;
    end

    assign q_push.valid = front_valid_reg;
    assign q_push.cmd   = front_cmd_reg;

endmodule

`default_nettype wire

// File: hw/rtl/igts_queue.sv
// Short command queue between the front end and the execution sequencer.
`timescale 1ns / 1ps
`default_nettype none

module igts_queue
    import igts_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  cmd_push_t q_push,
    output logic      q_full,
    output logic      q_empty,
    output cmd_t      q_head,
    input  wire logic q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign q_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign q_head  = slot_reg[rd_ptr_reg];
    assign do_push = q_push.valid && !q_full;
    assign do_pop  = q_pop && !q_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= q_push.cmd;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/igts_back.sv
// Execution sequencer: task table, idle check, schedule scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module igts_back
    import igts_pkg::*;
#(
    parameter int MAX_TASKS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    input  wire logic                   q_empty,
    input  cmd_t                        q_head,
    output logic                        q_pop,
    input  wire logic                   pop,
    output logic                        empty,
    output logic                        fired,
    output logic [OUT_IDX_W-1:0]        fired_index,
    output logic                        table_full,
    output logic [CFG_W-1:0]            idle_count
);

    localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int SPLIT  = 24;
    localparam int PP_W   = CFG_W + SPLIT;
    localparam int PROD_W = CFG_W + TIME_W;
    localparam int NMAG_W = TIME_W + 10;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_ADD      = 9'b000000010,
        S_DIFF     = 9'b000000100,
        S_MUL0     = 9'b000001000,
        S_MUL1     = 9'b000010000,
        S_CHECK    = 9'b000100000,
        S_SCAN_RD  = 9'b001000000,
        S_SCAN_CHK = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CFG_W-1:0]    cpu_thr_reg;
    logic [CFG_W-1:0]    needed_reg;
    logic [CFG_W-1:0]    chk_int_reg;
    cmd_t                cmd_reg;
    cmd_t                cmd_next;
    logic [TIME_W-1:0]   last_check_reg;
    logic [TIME_W-1:0]   last_check_next;
    logic [TIME_W-1:0]   last_cpu_reg;
    logic [TIME_W-1:0]   last_cpu_next;
    logic [CFG_W-1:0]    idle_cnt_reg;
    logic [CFG_W-1:0]    idle_cnt_next;
    logic [CNT_W-1:0]    total_reg;
    logic [CNT_W-1:0]    total_next;
    logic [TIME_W:0]     dtw_reg;
    logic [TIME_W:0]     dtw_next;
    logic [TIME_W:0]     dtc_reg;
    logic [TIME_W:0]     dtc_next;
    logic [TIME_W-1:0]   dtc_mag_reg;
    logic [TIME_W-1:0]   dtc_mag_next;
    logic [NMAG_W-1:0]   nmag_reg;
    logic [NMAG_W-1:0]   nmag_next;
    logic [PP_W-1:0]     p0_reg;
    logic [PP_W-1:0]     p0_next;
    logic [PP_W-1:0]     p1_reg;
    logic [PP_W-1:0]     p1_next;
    logic [CNT_W-1:0]    scan_reg;
    logic [CNT_W-1:0]    scan_next;
    logic                pend_fired_reg;
    logic                pend_fired_next;
    logic                pend_full_reg;
    logic                pend_full_next;
    logic [IDX_W-1:0]    pend_idx_reg;
    logic [IDX_W-1:0]    pend_idx_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_fired_reg;
    logic                out_full_reg;
    logic [OUT_IDX_W-1:0] out_idx_reg;
    logic [CFG_W-1:0]    out_count_reg;
    logic                out_load;

    task_t               task_mem [MAX_TASKS];
    task_t               rd_data_reg;
    logic                rd_en;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    task_t               mem_wdata;

    logic [PP_W-1:0]     thr_ext;
    logic [TIME_W:0]     dtc_neg;
    logic [PROD_W-1:0]   prod;
    logic                do_check;
    logic                dtw_zero;
    logic                is_idle;
    logic [CFG_W-1:0]    cnt_sat;

    assign thr_ext  = {{SPLIT{1'b0}}, cpu_thr_reg};
    assign dtc_neg  = '0 - dtc_reg;
    assign prod     = {{(PROD_W-PP_W){1'b0}}, p0_reg} + {p1_reg, {SPLIT{1'b0}}};
    assign do_check = !dtw_reg[TIME_W]
                      && (dtw_reg[TIME_W-1:0] >= {{(TIME_W-CFG_W){1'b0}}, chk_int_reg});
    assign dtw_zero = (dtw_reg == '0);
    assign cnt_sat  = (idle_cnt_reg == IDLE_COUNT_MAX) ? idle_cnt_reg : idle_cnt_reg + 1'b1;
    assign rd_en    = (state_reg == S_SCAN_RD) && (scan_reg < total_reg);

    always_comb
    begin
        priority if (dtw_zero)
        begin
            is_idle = dtc_reg[TIME_W]
                      || (dtc_reg[TIME_W-1:0] < {{(TIME_W-CFG_W){1'b0}}, cpu_thr_reg});
        end
        else if (!dtc_reg[TIME_W])
        begin
            is_idle = {{(PROD_W-NMAG_W){1'b0}}, nmag_reg} < prod;
        end
        else
        begin
            is_idle = (cpu_thr_reg != '0)
                      || (nmag_reg >= {{(NMAG_W-TIME_W){1'b0}}, dtw_reg[TIME_W-1:0]});
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        last_check_next = last_check_reg;
        last_cpu_next   = last_cpu_reg;
        idle_cnt_next   = idle_cnt_reg;
        total_next      = total_reg;
        dtw_next        = dtw_reg;
        dtc_next        = dtc_reg;
        dtc_mag_next    = dtc_mag_reg;
        nmag_next       = nmag_reg;
        p0_next         = p0_reg;
        p1_next         = p1_reg;
        scan_next       = scan_reg;
        pend_fired_next = pend_fired_reg;
        pend_full_next  = pend_full_reg;
        pend_idx_next   = pend_idx_reg;
        q_pop           = 1'b0;
        out_load        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = total_reg[IDX_W-1:0];
        mem_wdata       = '{interval: cmd_reg.period, due: cmd_reg.due};

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop           = 1'b1;
                    cmd_next        = q_head;
                    pend_fired_next = 1'b0;
                    pend_full_next  = 1'b0;
                    pend_idx_next   = '0;
                    state_next      = (q_head.kind == CMD_ADD) ? S_ADD : S_DIFF;
                end
            end
            S_ADD:
            begin
                if (total_reg == CNT_W'(MAX_TASKS))
                begin
                    pend_full_next = 1'b1;
                end
                else
                begin
                    mem_we        = 1'b1;
                    pend_idx_next = total_reg[IDX_W-1:0];
                    total_next    = total_reg + 1'b1;
                end
                state_next = S_DONE;
            end
            S_DIFF:
            begin
                dtw_next   = {1'b0, cmd_reg.wall} - {1'b0, last_check_reg};
                dtc_next   = {1'b0, cmd_reg.cpu} - {1'b0, last_cpu_reg};
                state_next = S_MUL0;
            end
            S_MUL0:
            begin
                p0_next      = thr_ext * {{(PP_W-SPLIT){1'b0}}, dtw_reg[SPLIT-1:0]};
                dtc_mag_next = dtc_reg[TIME_W] ? dtc_neg[TIME_W-1:0] : dtc_reg[TIME_W-1:0];
                state_next   = S_MUL1;
            end
            S_MUL1:
            begin
                p1_next    = thr_ext * {{(PP_W-(TIME_W-SPLIT)){1'b0}},
                                        dtw_reg[TIME_W-1:SPLIT]};
                nmag_next  = {dtc_mag_reg, 10'd0}
                             - {6'd0, dtc_mag_reg, 4'd0}
                             - {7'd0, dtc_mag_reg, 3'd0};
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (do_check)
                begin
                    last_check_next = cmd_reg.wall;
                    last_cpu_next   = cmd_reg.cpu;
                    idle_cnt_next   = is_idle ? cnt_sat : '0;
                end
                scan_next = '0;
                if (idle_cnt_next >= needed_reg)
                begin
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN_RD:
            begin
                state_next = (scan_reg < total_reg) ? S_SCAN_CHK : S_DONE;
            end
            S_SCAN_CHK:
            begin
                if (cmd_reg.wall >= rd_data_reg.due)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = scan_reg[IDX_W-1:0];
                    mem_wdata       = '{interval: rd_data_reg.interval,
                                        due: cmd_reg.wall
                                             + {{(TIME_W-PERIOD_W){1'b0}},
                                                rd_data_reg.interval}};
                    idle_cnt_next   = '0;
                    pend_fired_next = 1'b1;
                    pend_idx_next   = scan_reg[IDX_W-1:0];
                    state_next      = S_DONE;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cpu_thr_reg    <= CPU_IDLE_THRESHOLD_RST;
            needed_reg     <= IDLE_CHECKS_NEEDED_RST;
            chk_int_reg    <= CHECK_INTERVAL_RST;
            last_check_reg <= '0;
            last_cpu_reg   <= '0;
            idle_cnt_reg   <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_check_reg <= last_check_next;
            last_cpu_reg   <= last_cpu_next;
            idle_cnt_reg   <= idle_cnt_next;
            total_reg      <= total_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CPU_IDLE_THRESHOLD: cpu_thr_reg <= cfg_data;
                    REG_IDLE_CHECKS_NEEDED: needed_reg  <= cfg_data;
                    REG_CHECK_INTERVAL:     chk_int_reg <= cfg_data;
                    default:                ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        dtw_reg        <= dtw_next;
        dtc_reg        <= dtc_next;
        dtc_mag_reg    <= dtc_mag_next;
        nmag_reg       <= nmag_next;
        p0_reg         <= p0_next;
        p1_reg         <= p1_next;
        scan_reg       <= scan_next;
        pend_fired_reg <= pend_fired_next;
        pend_full_reg  <= pend_full_next;
        pend_idx_reg   <= pend_idx_next;
        if (out_load)
        begin
            out_fired_reg <= pend_fired_reg;
            out_full_reg  <= pend_full_reg;
            out_idx_reg   <= OUT_IDX_W'(pend_idx_reg);
            out_count_reg <= idle_cnt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            task_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= task_mem[scan_reg[IDX_W-1:0]];
        end
    end

    assign empty       = !out_valid_reg;
    assign fired       = out_fired_reg;
    assign table_full  = out_full_reg;
    assign fired_index = out_idx_reg;
    assign idle_count  = out_count_reg;

endmodule

`default_nettype wire

// File: hw/rtl/idle_gated_task_scheduler.sv
// Top level of the idle-gated task scheduler.
// An add item stores a periodic task in the next free table slot and reports
// its index, or sets table_full when all MAX_TASKS slots are taken. A poll item
// runs an idle check once check_interval wall ms have passed, counts idle
// checks and, when the count reaches idle_checks_needed, launches the first
// due task in table order. Every item gives exactly one result. Items enter a
// front register and a two-entry command queue, so new items are taken while a
// result waits to be popped. The sequencer handles one item at a time; a poll
// whose count reaches idle_checks_needed scans the table, reading the task
// entries one at a time through the task memory's single registered read
// port. Nothing needs clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module idle_gated_task_scheduler
    import igts_pkg::*;
#(
    parameter int MAX_TASKS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic                   func,
    input  wire logic [TIME_W-1:0]      wall_now,
    input  wire logic [TIME_W-1:0]      cpu_now,
    input  wire logic [PERIOD_W-1:0]    task_period,
    input  wire logic                   pop,
    output logic                        empty,
    output logic                        fired,
    output logic [OUT_IDX_W-1:0]        fired_index,
    output logic                        table_full,
    output logic [CFG_W-1:0]            idle_count
);

    cmd_push_t q_push;
    logic      q_full;
    logic      q_empty;
    cmd_t      q_head;
    logic      q_pop;

    igts_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .func        (func),
        .wall_now    (wall_now),
        .cpu_now     (cpu_now),
        .task_period (task_period),
        .q_push      (q_push),
        .q_full      (q_full)
    );

    igts_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    igts_back #(
        .MAX_TASKS (MAX_TASKS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .fired       (fired),
        .fired_index (fired_index),
        .table_full  (table_full),
        .idle_count  (idle_count)
    );

endmodule

`default_nettype wire

// File: hw/rtl/igts_checker.sv
// Port-level checker for the idle-gated task scheduler and its bind.
`timescale 1ns / 1ps
`default_nettype none

module igts_port_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pop,
    input wire logic        empty,
    input wire logic        fired,
    input wire logic [3:0]  fired_index,
    input wire logic        table_full,
    input wire logic [15:0] idle_count
);

    a_fire_clears_count: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && fired) |-> (idle_count == 16'd0)
    ) else $error("launched item with nonzero idle count");

    a_full_has_no_task: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && table_full) |-> (!fired && (fired_index == 4'd0))
    ) else $error("dropped add reports a task");

    a_result_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(fired) && $stable(fired_index)
                              && $stable(table_full) && $stable(idle_count))
    ) else $error("waiting item changed or vanished");

endmodule

bind idle_gated_task_scheduler igts_port_checker u_igts_port_checker (.*);

`default_nettype wire

// File: test/igts_checker.sv
// Scoreboard for the idle-gated task scheduler: predicts each result and compares it.
`timescale 1ns / 1ps

module igts_checker
    import igts_pkg::*;
#(
    parameter int MAX_TASKS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   push,
    input  logic                   full,
    input  logic                   func,
    input  logic [TIME_W-1:0]      wall_now,
    input  logic [TIME_W-1:0]      cpu_now,
    input  logic [PERIOD_W-1:0]    task_period,
    input  logic                   pop,
    input  logic                   empty,
    input  logic                   fired,
    input  logic [OUT_IDX_W-1:0]   fired_index,
    input  logic                   table_full,
    input  logic [CFG_W-1:0]       idle_count,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic                 launched;
        logic [OUT_IDX_W-1:0] index;
        logic                 dropped;
        logic [CFG_W-1:0]     count;
    } outcome_t;

    outcome_t outcome_q[$];

    logic [CFG_W-1:0]    idle_threshold;
    logic [CFG_W-1:0]    checks_needed;
    logic [CFG_W-1:0]    min_gap;
    logic [TIME_W-1:0]   last_wall;
    logic [TIME_W-1:0]   last_cpu;
    logic [CFG_W-1:0]    idle_ctr;
    int                  n_tasks;
    logic [PERIOD_W-1:0] task_int [MAX_TASKS];
    logic [TIME_W-1:0]   task_due [MAX_TASKS];

    initial fail_count = 0;
    initial pending = 0;

    function automatic longint time_diff(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
        return $signed({16'd0, a}) - $signed({16'd0, b});
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < 100)
            $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic advance_schedule(input logic kind, input logic [TIME_W-1:0] wall,
                                    input logic [TIME_W-1:0] cpu,
                                    input logic [PERIOD_W-1:0] period,
                                    output outcome_t res);
        longint dt_wall;
        longint dt_cpu;
        longint rate;
        int     i;
        bit     hit;
        res = '0;
        if (kind == CMD_ADD)
        begin
            if (n_tasks >= MAX_TASKS)
                res.dropped = 1'b1;
            else
            begin
                task_int[n_tasks] = period;
                task_due[n_tasks] = wall + period;
                res.index = OUT_IDX_W'(n_tasks);
                n_tasks++;
            end
        end
        else
        begin
            dt_wall = time_diff(wall, last_wall);
            if (dt_wall >= longint'(min_gap))
            begin
                dt_cpu = time_diff(cpu, last_cpu);
                if (dt_wall > 0)
                    rate = (dt_cpu * 1000) / dt_wall;
                else
                    rate = dt_cpu;
                last_cpu = cpu;
                last_wall = wall;
                if (rate < longint'(idle_threshold))
                begin
                    if (idle_ctr != IDLE_COUNT_MAX)
                        idle_ctr++;
                end
                else
                    idle_ctr = '0;
            end
            if (idle_ctr >= checks_needed)
            begin
                hit = 1'b0;
                for (i = 0; i < n_tasks && !hit; i++)
                begin
                    if (time_diff(wall, task_due[i]) >= 0)
                    begin
                        task_due[i] = wall + task_int[i];
                        idle_ctr = '0;
                        res.launched = 1'b1;
                        res.index = OUT_IDX_W'(i);
                        hit = 1'b1;
                    end
                end
            end
        end
        res.count = idle_ctr;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        outcome_t next;
        if (!rst_n)
        begin
            idle_threshold = CPU_IDLE_THRESHOLD_RST;
            checks_needed = IDLE_CHECKS_NEEDED_RST;
            min_gap = CHECK_INTERVAL_RST;
            last_wall = '0;
            last_cpu = '0;
            idle_ctr = '0;
            n_tasks = 0;
            outcome_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CPU_IDLE_THRESHOLD: idle_threshold = cfg_data;
                    REG_IDLE_CHECKS_NEEDED: checks_needed = cfg_data;
                    REG_CHECK_INTERVAL:     min_gap = cfg_data;
                    default: ;
                endcase
            end
            if (pop && !empty)
            begin
                if (outcome_q.size() == 0)
                    report_mismatch("result with nothing expected", idle_count, 0);
                else
                begin
                    want = outcome_q.pop_front();
                    if (fired !== want.launched)
                        report_mismatch("fired", fired, want.launched);
                    if (fired_index !== want.index)
                        report_mismatch("fired_index", fired_index, want.index);
                    if (table_full !== want.dropped)
                        report_mismatch("table_full", table_full, want.dropped);
                    if (idle_count !== want.count)
                        report_mismatch("idle_count", idle_count, want.count);
                end
            end
            if (push && !full)
            begin
                advance_schedule(func, wall_now, cpu_now, task_period, next);
                outcome_q.push_back(next);
            end
            pending <= outcome_q.size();
        end
    end

endmodule

// File: test/tb_idle_gated_task_scheduler.sv
// Stimulus and verdict for the idle-gated task scheduler.
`timescale 1ns / 1ps

module tb_idle_gated_task_scheduler;
    import igts_pkg::*;

    localparam int MAX_TASKS      = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 100;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   push = 1'b0;
    logic                   full;
    logic                   func = 1'b0;
    logic [TIME_W-1:0]      wall_now = '0;
    logic [TIME_W-1:0]      cpu_now = '0;
    logic [PERIOD_W-1:0]    task_period = '0;
    logic                   pop = 1'b0;
    logic                   empty;
    logic                   fired;
    logic [OUT_IDX_W-1:0]   fired_index;
    logic                   table_full;
    logic [CFG_W-1:0]       idle_count;
    int                     fail_count;
    int                     pending;

    int                     send_idle = 20;
    int                     recv_idle = 71;
    int                     quiet = 0;
    logic [TIME_W-1:0]      cur_wall;
    logic [TIME_W-1:0]      cur_cpu;

    idle_gated_task_scheduler #(.MAX_TASKS(MAX_TASKS)) i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .push(push), .full(full), .func(func),
        .wall_now(wall_now), .cpu_now(cpu_now), .task_period(task_period),
        .pop(pop), .empty(empty), .fired(fired), .fired_index(fired_index),
        .table_full(table_full), .idle_count(idle_count)
    );

    igts_checker #(.MAX_TASKS(MAX_TASKS)) i_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .push(push), .full(full), .func(func),
        .wall_now(wall_now), .cpu_now(cpu_now), .task_period(task_period),
        .pop(pop), .empty(empty), .fired(fired), .fired_index(fired_index),
        .table_full(table_full), .idle_count(idle_count),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    always @(posedge clk)
        pop <= ($urandom_range(0, 99) >= recv_idle);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet <= 0;
            else if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    function automatic logic [TIME_W-1:0] rand48();
        return TIME_W'({$urandom(), $urandom()});
    endfunction

    task automatic send_item(input cmd_kind_t kind, input logic [TIME_W-1:0] wall,
                             input logic [TIME_W-1:0] cpu,
                             input logic [PERIOD_W-1:0] period);
        while ($urandom_range(0, 99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        func <= kind;
        wall_now <= wall;
        cpu_now <= cpu;
        task_period <= period;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic drain();
        push <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic set_config(input int thr, input int needed, input int gap);
        cfg_we <= 1'b1;
        cfg_index <= REG_CPU_IDLE_THRESHOLD;
        cfg_data <= CFG_W'(thr);
        @(posedge clk);
        cfg_index <= REG_IDLE_CHECKS_NEEDED;
        cfg_data <= CFG_W'(needed);
        @(posedge clk);
        cfg_index <= REG_CHECK_INTERVAL;
        cfg_data <= CFG_W'(gap);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_item(input int thr, input int gap);
        int                pick;
        int                delta;
        int                rate_t;
        logic [TIME_W-1:0] w;
        pick = $urandom_range(0, 99);
        delta = $urandom_range(0, 2 * gap + 10);
        rate_t = $urandom_range(0, 2 * thr + 20);
        if (pick < 80)
        begin
            cur_wall = cur_wall + TIME_W'(delta);
            cur_cpu = cur_cpu + TIME_W'(longint'(delta) * rate_t / 1000);
            send_item(CMD_POLL, cur_wall, cur_cpu, PERIOD_W'($urandom()));
        end
        else if (pick < 87)
            send_item(CMD_ADD, rand48(), rand48(), PERIOD_W'($urandom()));
        else if (pick < 93)
        begin
            w = cur_wall - TIME_W'($urandom_range(1, 5000));
            send_item(CMD_POLL, w, rand48(), PERIOD_W'($urandom()));
        end
        else if (pick < 97)
        begin
            cur_wall = cur_wall + TIME_W'(delta);
            w = (cur_cpu > 1000) ? cur_cpu - TIME_W'($urandom_range(0, 1000)) : cur_cpu;
            send_item(CMD_POLL, cur_wall, w, PERIOD_W'($urandom()));
        end
        else
        begin
            w = rand48() >> 2;
            if (w > cur_wall)
                cur_wall = w;
            cur_cpu = cur_cpu + TIME_W'($urandom());
            send_item(CMD_POLL, cur_wall, cur_cpu, PERIOD_W'($urandom()));
        end
    endtask

    initial
    begin
        int thr_set[6];
        int needed_set[6];
        int gap_set[6];
        int p;
        int k;
        thr_set = '{150, 65535, 0, 300, 1000, 0};
        needed_set = '{2, 0, 1, 3, 65535, 0};
        gap_set = '{1000, 0, 65535, 500, 250, 0};
        thr_set[5] = $urandom_range(0, 2000);
        needed_set[5] = $urandom_range(0, 4);
        gap_set[5] = $urandom_range(0, 3000);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(CMD_POLL, '0, '0, '1);
        send_item(CMD_POLL, TIME_W'(1000), '0, '0);
        send_item(CMD_POLL, TIME_W'(500), '1, '0);
        drain();
        set_config(65535, 1, 0);
        send_item(CMD_POLL, TIME_W'(1000), TIME_W'(100), '0);
        for (k = 0; k < MAX_TASKS - 2; k++)
            send_item(CMD_ADD, TIME_W'(1000 + k), rand48(),
                      PERIOD_W'($urandom_range(1, 5000)));
        send_item(CMD_POLL, TIME_W'(1000), TIME_W'(50), '0);
        send_item(CMD_POLL, TIME_W'(20000), TIME_W'(200), '0);
        send_item(CMD_ADD, '1, '0, '1);
        send_item(CMD_ADD, '0, '0, '0);
        send_item(CMD_ADD, TIME_W'(30000), '0, PERIOD_W'(77));
        send_item(CMD_POLL, TIME_W'(20000), TIME_W'(200), '0);
        cur_wall = TIME_W'(20000);
        cur_cpu = TIME_W'(200);

        for (p = 0; p < 6; p++)
        begin
            drain();
            set_config(thr_set[p], needed_set[p], gap_set[p]);
            if (p < 2)
            begin
                send_idle = 20;
                recv_idle = 71;
            end
            else if (p < 4)
            begin
                send_idle = 71;
                recv_idle = 20;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 0 && k == PHASE_ITEMS / 2)
                    drain();
                send_random_item(thr_set[p], gap_set[p]);
            end
        end

        drain();
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/igts_pkg.sv
hw/rtl/igts_front.sv
hw/rtl/igts_queue.sv
hw/rtl/igts_back.sv
hw/rtl/idle_gated_task_scheduler.sv
hw/rtl/igts_checker.sv
test/igts_checker.sv
test/tb_idle_gated_task_scheduler.sv
